[hw/rtl/csa_pkg.sv]
// csa_pkg: shared types and constants for the concat and sort unit
// no dependencies
package csa_pkg;

	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 16;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} csa_state_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic load;
		logic shift;
	} csa_cell_ctrl_t;

endpackage

[hw/rtl/csa_cell.sv]
// csa_cell: one slot of the sorting chain, holds a value and a valid bit
// depends on csa_pkg
module csa_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  csa_pkg::csa_cell_ctrl_t             ctrl,
	input  logic signed [csa_pkg::DATA_W-1:0]   new_value,
	input  logic signed [csa_pkg::DATA_W-1:0]   left_value,
	input  logic                                left_valid,
	input  logic                                left_gt,
	input  logic signed [csa_pkg::DATA_W-1:0]   right_value,
	input  logic                                right_valid,
	output logic signed [csa_pkg::DATA_W-1:0]   value,
	output logic                                valid,
	output logic                                gt
);
	import csa_pkg::*;

	logic signed [DATA_W-1:0] value_q;
	logic                     valid_q;
	logic signed [DATA_W-1:0] value_d;
	logic                     valid_d;
	logic                     take_new;

	assign gt       = valid_q && (value_q > new_value);
	assign take_new = !left_gt && (gt || (!valid_q && left_valid));

	always_comb begin
		value_d = value_q;
		valid_d = valid_q;
		if (ctrl.shift) begin
			value_d = right_value;
			valid_d = right_valid;
		end else if (ctrl.load) begin
			if (left_gt) begin
				value_d = left_value;
				valid_d = 1'b1;
			end else if (take_new) begin
				value_d = new_value;
				valid_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;
	assign valid = valid_q;

endmodule

[hw/rtl/concat_and_sort_ascending_unit.sv]
// concat_and_sort_ascending_unit: top level, a chain of insertion cells
// depends on csa_pkg and csa_cell
//
// Signed 32-bit values enter one transaction per cycle and are inserted in
// ascending order into a chain of CAPACITY cells as they arrive, so the list is
// already sorted when the transaction flagged tlast is taken. The chain then
// shifts toward the output, one result per cycle while m_tready is high, the
// smallest first, with tlast on the final one. Each stored value takes one
// insertion into the chain and each result one shift of the whole chain; no
// input is taken while results are being sent. Values arriving with the chain
// full are dropped and m_tuser is high on every result of that run.
module concat_and_sort_ascending_unit #(
	parameter int CAPACITY = csa_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [csa_pkg::DATA_W-1:0]  s_tdata,  // [31:0] value
	input  logic                        s_tlast,  // last_item
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [csa_pkg::DATA_W-1:0]  m_tdata,  // [31:0] sorted_value
	output logic                        m_tlast,  // last_result
	output logic                        m_tuser   // overflow
);
	import csa_pkg::*;

	csa_state_t             state_q, state_d;
	logic                   drop_q, drop_d;
	csa_cell_ctrl_t         ctrl;
	logic                   s_acc, m_acc, full;

	logic signed [DATA_W-1:0] cell_value [CAPACITY];
	logic                     cell_valid [CAPACITY];
	logic                     cell_gt    [CAPACITY];

	assign full  = cell_valid[CAPACITY-1];
	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	assign ctrl.load  = s_acc && !full;
	assign ctrl.shift = m_acc;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic signed [DATA_W-1:0] lv, rv;
			logic                     lvld, lgt, rvld;
			if (i == 0) begin : g_first
				assign lv   = '0;
				assign lvld = 1'b1;
				assign lgt  = 1'b0;
			end else begin : g_mid
				assign lv   = cell_value[i-1];
				assign lvld = cell_valid[i-1];
				assign lgt  = cell_gt[i-1];
			end
			if (i == CAPACITY-1) begin : g_end
				assign rv   = '0;
				assign rvld = 1'b0;
			end else begin : g_inner
				assign rv   = cell_value[i+1];
				assign rvld = cell_valid[i+1];
			end
			csa_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.new_value   ($signed(s_tdata)),
				.left_value  (lv),
				.left_valid  (lvld),
				.left_gt     (lgt),
				.right_value (rv),
				.right_valid (rvld),
				.value       (cell_value[i]),
				.valid       (cell_valid[i]),
				.gt          (cell_gt[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			drop_q  <= drop_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		drop_d   = drop_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (full) begin
						drop_d = 1'b1;
					end
					if (s_tlast) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				m_tvalid = cell_valid[0];
				if (m_acc && m_tlast) begin
					state_d = ST_LOAD;
					drop_d  = 1'b0;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign m_tdata = cell_value[0];
	assign m_tlast = !cell_valid[1];
	assign m_tuser = drop_q;

endmodule

[hw/rtl/csa_checker.sv]
// csa_checker: port-level checks for concat_and_sort_ascending_unit
// bound to the top level at the end of this file
module csa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// no input taken while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while results pending");

	a_emit_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> m_tvalid)
		else $error("no result after final input transaction");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			(m_tvalid && ($signed(m_tdata) >= $signed($past(m_tdata)))))
		else $error("results not ascending");

	a_flag_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tuser == $past(m_tuser)))
		else $error("overflow flag changed within a run");

	a_ready_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("not ready for a new run");

endmodule

bind concat_and_sort_ascending_unit csa_checker u_csa_checker (.*);

[dv/concat_and_sort_ascending_unit_tb.sv]
// concat_and_sort_ascending_unit_tb: self-checking bench for the concat and sort unit
// drives value runs on the s_ side, checks every sorted result on the m_ side
// depends on csa_pkg and the unit under test
module concat_and_sort_ascending_unit_tb;
	import csa_pkg::*;

	localparam int CAPACITY   = CAPACITY_DEF;
	localparam int ITEMS      = 420;
	localparam int CALM_ITEMS = 60;
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              last;
		logic              ovf;
	} sorted_beat_t;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] step;
		int                reps;
		bit                lst;
		bit                typed;
		logic [DATA_W-1:0] want;
	} probe_row_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;
	logic              m_tuser;

	logic signed [DATA_W-1:0] loaded_vals[$];
	bit                       drop_seen;
	sorted_beat_t             fresh_beats[$];
	sorted_beat_t             sorted_due[$];
	probe_row_t               probe_tab[10];
	int                       error_count;
	int                       sent_count;
	int                       idle_cycles;
	bit                       calm;

	concat_and_sort_ascending_unit #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),   // [31:0] value
		.s_tlast (s_tlast),   // last_item
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),   // [31:0] sorted_value
		.m_tlast (m_tlast),   // last_result
		.m_tuser (m_tuser)    // overflow
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		$display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $realtime);
		error_count++;
	endtask

	// stores or drops one value; on the last one sorts the run into fresh_beats
	function automatic void load_and_sort(input logic [DATA_W-1:0] v, input logic lst);
		logic signed [DATA_W-1:0] arr[CAPACITY];
		logic signed [DATA_W-1:0] t;
		sorted_beat_t             b;
		int                       n;
		int                       i;
		int                       p;
		fresh_beats.delete();
		if (loaded_vals.size() < CAPACITY) begin
			loaded_vals.push_back(v);
		end else begin
			drop_seen = 1'b1;
		end
		if (lst) begin
			n = loaded_vals.size();
			for (i = 0; i < n; i++) arr[i] = loaded_vals[i];
			// strict exchange keeps equal values in load order
			for (p = 0; p < n; p++) begin
				for (i = 0; i + 1 < n; i++) begin
					if (arr[i] > arr[i + 1]) begin
						t = arr[i];
						arr[i] = arr[i + 1];
						arr[i + 1] = t;
					end
				end
			end
			for (i = 0; i < n; i++) begin
				b.value = arr[i];
				b.last  = (i == n - 1);
				b.ovf   = drop_seen;
				fresh_beats.push_back(b);
			end
			loaded_vals.delete();
			drop_seen = 1'b0;
		end
	endfunction

	task automatic send_value(input logic [DATA_W-1:0] v, input logic lst, input bit typed,
			input logic [DATA_W-1:0] want);
		sorted_beat_t b;
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		sent_count++;
		load_and_sort(v, lst);
		if (typed) begin
			b.value = want;
			b.last  = 1'b1;
			b.ovf   = 1'b0;
			sorted_due.push_back(b);
		end else begin
			foreach (fresh_beats[i]) sorted_due.push_back(fresh_beats[i]);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sorted_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_value(input int mode);
		logic [DATA_W-1:0] v;
		v = $urandom;
		case (mode)
			1: begin
				v = $urandom_range(0, 8);
				v = v - 32'd4;
			end
			2: begin
				case ($urandom_range(0, 5))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'h0000_0000;
					3: v = 32'hffff_ffff;
					4: v = 32'h0000_0001;
					default: v = $urandom;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// results side
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (sorted_due.size() == 0) begin
				flag_mismatch("unexpected result", '0, m_tdata);
			end else begin
				if (m_tdata !== sorted_due[0].value)
					flag_mismatch("sorted_value", sorted_due[0].value, m_tdata);
				if (m_tlast !== sorted_due[0].last)
					flag_mismatch("last_result", sorted_due[0].last, m_tlast);
				if (m_tuser !== sorted_due[0].ovf)
					flag_mismatch("overflow", sorted_due[0].ovf, m_tuser);
				void'(sorted_due.pop_front());
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver back-pressure
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (calm) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		int len;
		int mode;
		int runs;
		int i;
		logic [DATA_W-1:0] v;
		error_count = 0;
		sent_count  = 0;
		idle_cycles = 0;
		calm        = 1'b0;
		drop_seen   = 1'b0;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tlast     <= 1'b0;

		// single values after reset read straight back; the rest go through the predictor
		probe_tab[0] = '{32'h8000_0000, 32'd0, 1, 1'b1, 1'b1, 32'h8000_0000};
		probe_tab[1] = '{32'h7fff_ffff, 32'd0, 1, 1'b1, 1'b1, 32'h7fff_ffff};
		probe_tab[2] = '{32'h0000_0000, 32'd0, 1, 1'b1, 1'b1, 32'h0000_0000};
		probe_tab[3] = '{32'hffff_ffff, 32'd0, 1, 1'b1, 1'b1, 32'hffff_ffff};
		probe_tab[4] = '{32'h7fff_ffff, 32'd0, 1, 1'b0, 1'b0, 32'd0};
		probe_tab[5] = '{32'h8000_0000, 32'd0, 1, 1'b0, 1'b0, 32'd0};
		probe_tab[6] = '{32'h0000_0000, 32'd0, 1, 1'b1, 1'b0, 32'd0};
		probe_tab[7] = '{32'd7, 32'd0, 1, 1'b0, 1'b0, 32'd0};
		probe_tab[8] = '{-32'sd7, 32'd0, 1, 1'b0, 1'b0, 32'd0};
		// descending past capacity, the flagged last value itself is dropped
		probe_tab[9] = '{32'd100, -32'sd1, CAPACITY + 1, 1'b1, 1'b0, 32'd0};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_tab[r]) begin
			v = probe_tab[r].value;
			for (i = 0; i < probe_tab[r].reps; i++) begin
				send_value(v, probe_tab[r].lst && (i == probe_tab[r].reps - 1),
					probe_tab[r].typed, probe_tab[r].want);
				v = v + probe_tab[r].step;
			end
		end
		// a lone seven, flagged last, as a run of its own
		send_value(32'd7, 1'b1, 1'b0, '0);
		drain_results();

		runs = 0;
		while (sent_count < ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: len = $urandom_range(1, 8);
				6, 7: len = $urandom_range(9, 16);
				8: len = CAPACITY;
				default: len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
			endcase
			mode = $urandom_range(0, 3);
			for (i = 0; i < len; i++) begin
				if (sent_count >= ITEMS - CALM_ITEMS) calm = 1'b1;
				send_value(pick_value(mode), i == len - 1, 1'b0, '0);
			end
			runs++;
			if (runs % 10 == 0) drain_results();
		end

		s_tvalid <= 1'b0;
		while (sorted_due.size() != 0) @(posedge clk);
		repeat (3 * CAPACITY + 10) @(posedge clk);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
